// File: rtl/core/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths, constants and types of the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned TDATA_W = 24;   // code point padded to whole bytes

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // Results raised by one input byte: up to three replacements for a broken
    // sequence, then at most one tail result (decoded code point or error).
    typedef struct packed {
        logic [1:0]      rep_cnt;
        logic            tail_valid;
        logic [CP_W-1:0] tail_cp;
        logic            tail_repl;
    } utf8d_burst_t;

endpackage

// File: rtl/core/utf8d_decode.sv
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and combinational decode of one byte into a result burst.
// ----------------------------------------------------------------------------
module utf8d_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              data_byte,
    output utf8d_pkg::utf8d_burst_t burst
);
    import utf8d_pkg::*;

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [1:0]      needed_reg, needed_next;
    logic [1:0]      taken_reg, taken_next;
    logic            is_cont;

    assign is_cont = (data_byte[7:6] == 2'b10);

    always_comb
    begin
        burst        = '0;
        partial_next = partial_reg;
        needed_next  = needed_reg;
        taken_next   = taken_reg;
        if ((needed_reg != 2'd0) && is_cont)
        begin
            partial_next = {partial_reg[CP_W-7:0], data_byte[5:0]};
            needed_next  = needed_reg - 2'd1;
            taken_next   = taken_reg + 2'd1;
            if (needed_reg == 2'd1)
            begin
                burst.tail_valid = 1'b1;
                burst.tail_cp    = {partial_reg[CP_W-7:0], data_byte[5:0]};
                partial_next     = '0;
                taken_next       = 2'd0;
            end
        end
        else
        begin
            // broken sequence: one replacement for the lead and each taken byte
            if (needed_reg != 2'd0)
                burst.rep_cnt = (taken_reg == 2'd3) ? 2'd3 : taken_reg + 2'd1;
            partial_next = '0;
            needed_next  = 2'd0;
            taken_next   = 2'd0;
            unique casez (data_byte)
                8'b0???????:
                begin
                    burst.tail_valid = 1'b1;
                    burst.tail_cp    = {{(CP_W-BYTE_W){1'b0}}, data_byte};
                end
                8'b110?????:
                begin
                    partial_next = {{(CP_W-5){1'b0}}, data_byte[4:0]};
                    needed_next  = 2'd1;
                end
                8'b1110????:
                begin
                    partial_next = {{(CP_W-4){1'b0}}, data_byte[3:0]};
                    needed_next  = 2'd2;
                end
                8'b11110???:
                begin
                    partial_next = {{(CP_W-3){1'b0}}, data_byte[2:0]};
                    needed_next  = 2'd3;
                end
                default:
                begin
                    // stray continuation or invalid lead
                    burst.tail_valid = 1'b1;
                    burst.tail_cp    = REPL_CP;
                    burst.tail_repl  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            needed_reg  <= 2'd0;
            taken_reg   <= 2'd0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            needed_reg  <= needed_next;
            taken_reg   <= taken_next;
        end
    end

endmodule

// File: rtl/core/utf8d_out.sv
// ----------------------------------------------------------------------------
// utf8d_out
// Result register: holds one byte's burst and hands it out one per request.
// ----------------------------------------------------------------------------
module utf8d_out (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  utf8d_pkg::utf8d_burst_t   burst,
    input  logic                      take,
    output logic                      can_load,
    output logic                      res_valid,
    output logic [utf8d_pkg::CP_W-1:0] res_cp,
    output logic                      res_repl,
    output logic                      res_last
);
    import utf8d_pkg::*;

    logic [1:0]      rep_cnt_reg, rep_cnt_next;
    logic            tail_valid_reg, tail_valid_next;
    logic [CP_W-1:0] tail_cp_reg;
    logic            tail_repl_reg;
    logic            single;

    assign res_valid = (rep_cnt_reg != 2'd0) || tail_valid_reg;
    assign res_cp    = (rep_cnt_reg != 2'd0) ? REPL_CP : tail_cp_reg;
    assign res_repl  = (rep_cnt_reg != 2'd0) ? 1'b1 : tail_repl_reg;
    assign single    = ((rep_cnt_reg == 2'd1) && !tail_valid_reg)
                    || ((rep_cnt_reg == 2'd0) && tail_valid_reg);
    assign res_last  = single;
    // room for a new burst once the last pending result leaves this cycle
    assign can_load  = !res_valid || (take && single);

    always_comb
    begin
        rep_cnt_next    = rep_cnt_reg;
        tail_valid_next = tail_valid_reg;
        if (load)
        begin
            rep_cnt_next    = burst.rep_cnt;
            tail_valid_next = burst.tail_valid;
        end
        else if (take && res_valid)
        begin
            if (rep_cnt_reg != 2'd0)
                rep_cnt_next = rep_cnt_reg - 2'd1;
            else
                tail_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_cnt_reg    <= 2'd0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            rep_cnt_reg    <= rep_cnt_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tail_cp_reg   <= burst.tail_cp;
            tail_repl_reg <= burst.tail_repl;
        end
    end

endmodule

// File: rtl/core/utf8_code_point_decoder.sv
// ----------------------------------------------------------------------------
// utf8_code_point_decoder
// Streaming UTF-8 decoder: one byte per request in, code points out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (s_*): one raw UTF-8 byte per request in s_tdata.
//   Master side (m_*): one code point per request; m_tuser flags a decoding
//   error (U+FFFD), m_tlast marks the final result raised by an input byte.
//   A byte is decoded in the cycle it is taken; its results sit in the result
//   register from the next cycle.
//   Throughput is one byte per cycle while each byte raises at most one
//   result and the receiver keeps m_tready high. A broken sequence raises up
//   to four results from one byte; with m_tready high the result register
//   hands them out one per cycle; s_tready is low until the last is taken.
//   A byte that only opens or extends a sequence raises no result.
//   Reset (rst_n low) closes any open sequence and empties the result
//   register. When the receiver stalls, the result register holds and
//   s_tready stays low for any byte while results are held and not taken.
//   An unfinished sequence at the end of a stream is held, never flushed.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [20:0] code_point, [23:21] zero
    output logic        m_tuser,    // [0] is_replacement
    output logic        m_tlast     // last_of_run
);
    import utf8d_pkg::*;

    utf8d_burst_t    burst;
    logic            s_accept;
    logic            can_load;
    logic [CP_W-1:0] res_cp;

    assign s_tready = can_load;
    assign s_accept = s_tvalid && s_tready;

    // decode stage: sequence state plus per-byte burst
    utf8d_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (s_accept),
        .data_byte (s_tdata),
        .burst     (burst)
    );

    // result register, drained one code point per request
    utf8d_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s_accept),
        .burst     (burst),
        .take      (m_tready),
        .can_load  (can_load),
        .res_valid (m_tvalid),
        .res_cp    (res_cp),
        .res_repl  (m_tuser),
        .res_last  (m_tlast)
    );

    assign m_tdata = {{(TDATA_W-CP_W){1'b0}}, res_cp};

    // a byte is taken only when the result register is free this cycle
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |-> (!m_tvalid || (m_tready && m_tlast)))
        else $error("byte taken while results still pending");

    // error results always carry the replacement character
    a_repl_cp: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[CP_W-1:0] == REPL_CP))
        else $error("error flag without U+FFFD");

    // a non-final result is always followed by more results of the burst
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |=> m_tvalid)
        else $error("burst ended without a last result");

    // a burst with results shows up in the next cycle
    a_burst_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && ((burst.rep_cnt != 2'd0) || burst.tail_valid)) |=> m_tvalid)
        else $error("results of a byte were lost");

endmodule
